// File: hdl/jtag_master_shift_engine_top_macros.svh
// Assertion macros used by the JTAG shift engine top level.
`ifndef JTAG_MASTER_SHIFT_ENGINE_TOP_MACROS_SVH
`define JTAG_MASTER_SHIFT_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define JMSE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in shift engine");
// Checks that the consequent holds in the cycle after the antecedent.
`define JMSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in shift engine");
`else
`define JMSE_ASSERT_SAME(lbl, ante, cons)
`define JMSE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/jmse_pkg.sv
// Types and constants for the JTAG shift engine.
package jmse_pkg;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SHIFT    = 2'd1,
    OP_STROBE   = 2'd2,
    OP_SET_PINS = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SHIFT  = 2'd1,
    MODE_STROBE = 2'd2
  } mode_t;

  localparam logic [7:0] SHIFT_MSB = 8'h80;
  localparam logic [3:0] MAX_BITS = 4'd8;
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic       tdo_pin;
    logic [7:0] tdi_byte;
    logic [3:0] bit_count;
    logic [7:0] pulse_count;
    logic       tms_level;
    logic       tdi_level;
  } jmse_in_t;

  typedef struct packed {
    logic       tck_out;
    logic       tdi_out;
    logic       tms_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] captured_byte;
    logic       strobe_tdo;
    logic       rejected;
  } jmse_out_t;

endpackage

// File: hdl/jtag_master_shift_engine_top.sv
// Top level of the JTAG shift engine: command decode, TCK timing and pin state.
`include "jtag_master_shift_engine_top_macros.svh"

// The engine takes one word per clock cycle while in_stall is low, ticks and
// commands alike, and returns one result word for each. The whole update of
// the pin and timing state is a single combinational pass from the accepted
// input word into the state registers and the result register; the result
// goes to an output register, or to the one-word skid register behind it if
// out_stall holds the output. in_stall rises only while the skid register is
// occupied. half_period may be written at any time the engine is idle and
// reads as 2 after reset. COUNTER_WIDTH sets the width of the tick counter;
// a half-period never lasts longer than 2^COUNTER_WIDTH ticks.
module jtag_master_shift_engine_top
  import jmse_pkg::*;
#(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  jmse_in_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output jmse_out_t   out_word
);

  localparam int CMP_W = (COUNTER_WIDTH + 1 > 16) ? COUNTER_WIDTH + 1 : 16;

  logic [15:0] half_period;

  mode_t                    mode, mode_next;
  logic [COUNTER_WIDTH-1:0] tick_counter, tick_counter_next;
  logic                     clock_high_phase, clock_high_phase_next;
  logic [3:0]               bit_index, bit_index_next;
  logic [3:0]               bits_to_send, bits_to_send_next;
  logic [7:0]               shift_data, shift_data_next;
  logic [7:0]               capture_data, capture_data_next;
  logic [7:0]               pulses_left, pulses_left_next;
  logic                     tck, tck_next;
  logic                     tdi, tdi_next;
  logic                     tms, tms_next;

  logic                     in_accept;
  logic                     out_take;
  logic                     skid_valid;
  jmse_out_t                skid_word;
  jmse_out_t                result;

  logic [COUNTER_WIDTH:0]   cnt_inc;
  logic                     half_end;
  logic [COUNTER_WIDTH-1:0] cnt_after;
  logic [3:0]               nbits;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
    end else if (cfg_write_en) begin
      half_period <= cfg_write_data;
    end
  end

  // One tick of the half-period timer; the counter also ends a half-period
  // when it would wrap.
  always_comb begin
    cnt_inc   = {1'b0, tick_counter} + 1'b1;
    half_end  = (CMP_W'(cnt_inc) >= CMP_W'(half_period)) ||
                (tick_counter == {COUNTER_WIDTH{1'b1}});
    cnt_after = half_end ? '0 : cnt_inc[COUNTER_WIDTH-1:0];
    nbits     = (in_word.bit_count > MAX_BITS) ? MAX_BITS : in_word.bit_count;
  end

  always_comb begin
    mode_next             = mode;
    tick_counter_next     = tick_counter;
    clock_high_phase_next = clock_high_phase;
    bit_index_next        = bit_index;
    bits_to_send_next     = bits_to_send;
    shift_data_next       = shift_data;
    capture_data_next     = capture_data;
    pulses_left_next      = pulses_left;
    tck_next              = tck;
    tdi_next              = tdi;
    tms_next              = tms;
    result                = '0;

    if (op_t'(in_word.operation) == OP_TICK) begin
      if (mode == MODE_SHIFT) begin
        tick_counter_next = cnt_after;
        if (half_end) begin
          if (!clock_high_phase) begin
            tck_next              = 1'b1;
            clock_high_phase_next = 1'b1;
          end else begin
            if (in_word.tdo_pin) begin
              capture_data_next = capture_data | (SHIFT_MSB >> bit_index[2:0]);
            end
            tck_next              = 1'b0;
            clock_high_phase_next = 1'b0;
            bit_index_next        = bit_index + 1'b1;
            if (bit_index_next >= bits_to_send) begin
              result.done_res      = 1'b1;
              result.captured_byte = capture_data_next;
              mode_next            = MODE_IDLE;
            end else begin
              shift_data_next = {shift_data[6:0], 1'b0};
              tdi_next        = shift_data[6];
            end
          end
        end
      end else if (mode == MODE_STROBE) begin
        tick_counter_next = cnt_after;
        if (half_end) begin
          if (clock_high_phase) begin
            // The last high phase samples TDO for the strobe result.
            if (pulses_left <= 8'd1) begin
              capture_data_next = {7'b0, in_word.tdo_pin};
            end
            tck_next              = 1'b0;
            clock_high_phase_next = 1'b0;
          end else begin
            pulses_left_next = pulses_left - 1'b1;
            if (pulses_left_next == 8'd0) begin
              result.done_res   = 1'b1;
              result.strobe_tdo = capture_data[0];
              mode_next         = MODE_IDLE;
            end else begin
              tck_next              = 1'b1;
              clock_high_phase_next = 1'b1;
            end
          end
        end
      end
    end else if (mode != MODE_IDLE) begin
      result.rejected = 1'b1;
    end else begin
      case (op_t'(in_word.operation))
        OP_SHIFT: begin
          capture_data_next = '0;
          if (nbits == 4'd0) begin
            result.done_res = 1'b1;
          end else begin
            shift_data_next       = in_word.tdi_byte;
            bits_to_send_next     = nbits;
            bit_index_next        = '0;
            tick_counter_next     = '0;
            clock_high_phase_next = 1'b0;
            tck_next              = 1'b0;
            tdi_next              = in_word.tdi_byte[7];
            mode_next             = MODE_SHIFT;
          end
        end
        OP_STROBE: begin
          tms_next          = in_word.tms_level;
          tdi_next          = in_word.tdi_level;
          capture_data_next = '0;
          if (in_word.pulse_count == 8'd0) begin
            result.done_res   = 1'b1;
            result.strobe_tdo = in_word.tdo_pin;
          end else begin
            pulses_left_next      = in_word.pulse_count;
            tick_counter_next     = '0;
            clock_high_phase_next = 1'b1;
            tck_next              = 1'b1;
            mode_next             = MODE_STROBE;
          end
        end
        default: begin
          tms_next        = in_word.tms_level;
          tdi_next        = in_word.tdi_level;
          result.done_res = 1'b1;
        end
      endcase
    end

    result.tck_out  = tck_next;
    result.tdi_out  = tdi_next;
    result.tms_out  = tms_next;
    result.busy_res = (mode_next != MODE_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_IDLE;
      tick_counter     <= '0;
      clock_high_phase <= 1'b0;
      bit_index        <= '0;
      bits_to_send     <= '0;
      shift_data       <= '0;
      capture_data     <= '0;
      pulses_left      <= '0;
      tck              <= 1'b0;
      tdi              <= 1'b0;
      tms              <= 1'b0;
    end else if (in_accept) begin
      mode             <= mode_next;
      tick_counter     <= tick_counter_next;
      clock_high_phase <= clock_high_phase_next;
      bit_index        <= bit_index_next;
      bits_to_send     <= bits_to_send_next;
      shift_data       <= shift_data_next;
      capture_data     <= capture_data_next;
      pulses_left      <= pulses_left_next;
      tck              <= tck_next;
      tdi              <= tdi_next;
      tms              <= tms_next;
    end
  end

  // Output register with a one-word skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_word <= skid_word;
      end
    end else if (in_accept) begin
      if (!out_valid || out_take) begin
        out_word <= result;
      end else begin
        skid_word <= result;
      end
    end
  end

  `JMSE_ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid)
  `JMSE_ASSERT_SAME(a_tck_tracks_phase, 1'b1, tck == clock_high_phase)
  `JMSE_ASSERT_SAME(a_shift_index_range, mode == MODE_SHIFT, bit_index < bits_to_send)
  `JMSE_ASSERT_NEXT(a_reject_keeps_state,
      in_accept && mode != MODE_IDLE && op_t'(in_word.operation) != OP_TICK,
      $stable(shift_data) && $stable(pulses_left) && $stable(tick_counter))

endmodule

// File: sim/tb.sv
// Testbench for the JTAG shift engine: directed and random words checked against a predictor.
`timescale 1ns / 1ps

module tb
  import jmse_pkg::*;
();

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_WORDS = 120;

  class pin_engine_scoreboard;
    logic [15:0] half_period;
    mode_t       mode;
    logic [15:0] tick_count;
    logic        high_phase;
    logic [3:0]  bit_idx;
    logic [3:0]  bit_total;
    logic [7:0]  shift_reg;
    logic [7:0]  capture_reg;
    logic [7:0]  pulses_left;
    logic        tck;
    logic        tdi;
    logic        tms;
    jmse_out_t   expected_q[$];
    int          mismatches;

    function new();
      half_period = HALF_PERIOD_RESET;
      mode = MODE_IDLE;
      tick_count = '0;
      high_phase = 1'b0;
      bit_idx = '0;
      bit_total = '0;
      shift_reg = '0;
      capture_reg = '0;
      pulses_left = '0;
      tck = 1'b0;
      tdi = 1'b0;
      tms = 1'b0;
      mismatches = 0;
    endfunction

    function bit busy();
      return mode != MODE_IDLE;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_half_period(logic [15:0] value);
      half_period = value;
    endfunction

    // Counts one tick and reports whether the running half-period has ended.
    function bit half_done();
      if ({1'b0, tick_count} + 17'd1 >= {1'b0, half_period} || tick_count == 16'hFFFF) begin
        tick_count = '0;
        return 1'b1;
      end
      tick_count = tick_count + 16'd1;
      return 1'b0;
    endfunction

    function void note_input(jmse_in_t w);
      jmse_out_t  e;
      logic [3:0] nbits;
      e = '0;
      if (op_t'(w.operation) == OP_TICK) begin
        if (mode == MODE_SHIFT) begin
          if (half_done()) begin
            if (!high_phase) begin
              tck = 1'b1;
              high_phase = 1'b1;
            end else begin
              if (w.tdo_pin)
                capture_reg = capture_reg | (SHIFT_MSB >> bit_idx[2:0]);
              tck = 1'b0;
              high_phase = 1'b0;
              bit_idx = bit_idx + 4'd1;
              if (bit_idx >= bit_total) begin
                e.done_res = 1'b1;
                e.captured_byte = capture_reg;
                mode = MODE_IDLE;
              end else begin
                shift_reg = shift_reg << 1;
                tdi = shift_reg[7];
              end
            end
          end
        end else if (mode == MODE_STROBE) begin
          if (half_done()) begin
            if (high_phase) begin
              // TDO is taken at the end of the last high phase only.
              if (pulses_left <= 8'd1)
                capture_reg = {7'd0, w.tdo_pin};
              tck = 1'b0;
              high_phase = 1'b0;
            end else begin
              pulses_left = pulses_left - 8'd1;
              if (pulses_left == 8'd0) begin
                e.done_res = 1'b1;
                e.strobe_tdo = capture_reg[0];
                mode = MODE_IDLE;
              end else begin
                tck = 1'b1;
                high_phase = 1'b1;
              end
            end
          end
        end
      end else if (mode != MODE_IDLE) begin
        e.rejected = 1'b1;
      end else begin
        case (op_t'(w.operation))
          OP_SHIFT: begin
            nbits = (w.bit_count > MAX_BITS) ? MAX_BITS : w.bit_count;
            capture_reg = '0;
            if (nbits == 4'd0) begin
              e.done_res = 1'b1;
            end else begin
              shift_reg = w.tdi_byte;
              bit_total = nbits;
              bit_idx = '0;
              tick_count = '0;
              high_phase = 1'b0;
              tck = 1'b0;
              tdi = w.tdi_byte[7];
              mode = MODE_SHIFT;
            end
          end
          OP_STROBE: begin
            tms = w.tms_level;
            tdi = w.tdi_level;
            capture_reg = '0;
            if (w.pulse_count == 8'd0) begin
              e.done_res = 1'b1;
              e.strobe_tdo = w.tdo_pin;
            end else begin
              pulses_left = w.pulse_count;
              tick_count = '0;
              high_phase = 1'b1;
              tck = 1'b1;
              mode = MODE_STROBE;
            end
          end
          default: begin
            tms = w.tms_level;
            tdi = w.tdi_level;
            e.done_res = 1'b1;
          end
        endcase
      end
      e.tck_out = tck;
      e.tdi_out = tdi;
      e.tms_out = tms;
      e.busy_res = (mode != MODE_IDLE);
      expected_q.push_back(e);
    endfunction

    function void check_result(jmse_out_t r);
      jmse_out_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word %h with nothing outstanding", r);
        return;
      end
      e = expected_q.pop_front();
      if (r !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected tck %b tdi %b tms %b busy %b done %b ",
                    "cap %h stb %b rej %b, got tck %b tdi %b tms %b busy %b done %b ",
                    "cap %h stb %b rej %b"},
                   e.tck_out, e.tdi_out, e.tms_out, e.busy_res, e.done_res,
                   e.captured_byte, e.strobe_tdo, e.rejected,
                   r.tck_out, r.tdi_out, r.tms_out, r.busy_res, r.done_res,
                   r.captured_byte, r.strobe_tdo, r.rejected);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [15:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  jmse_in_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  jmse_out_t   out_word;

  pin_engine_scoreboard sb = new();

  int words_sent = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;
  bit hold_request = 1'b0;

  jtag_master_shift_engine_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic jmse_in_t random_word(op_t op);
    jmse_in_t w;
    w = jmse_in_t'($urandom);
    w.operation = op;
    return w;
  endfunction

  // Offers one word, with a random gap first, and returns at the edge that accepts it.
  task automatic send_word(input jmse_in_t w);
    while (idle_on && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    // A tick while idle changes nothing and does not count toward the budget.
    if (!(op_t'(w.operation) == OP_TICK && !sb.busy()))
      words_sent++;
    sb.note_input(w);
  endtask

  // Ticks until the running command finishes, mixing in commands that must be rejected.
  task automatic run_to_done(input int reject_pct);
    jmse_in_t w;
    while (sb.busy()) begin
      if ($urandom_range(0, 99) < reject_pct)
        w = random_word(op_t'($urandom_range(1, 3)));
      else
        w = random_word(OP_TICK);
      send_word(w);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_half_period(input logic [15:0] value);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.set_half_period(value);
  endtask

  task automatic random_phase(input int count);
    int       stop_at;
    int       pick;
    jmse_in_t w;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        w = random_word(OP_SHIFT);
      end else if (pick < 75) begin
        w = random_word(OP_STROBE);
        // Long strobes are rare so that they do not eat the whole budget.
        if ($urandom_range(0, 29) != 0)
          w.pulse_count = 8'($urandom_range(0, 6));
      end else if (pick < 88) begin
        w = random_word(OP_SET_PINS);
      end else begin
        w = random_word(OP_TICK);
      end
      send_word(w);
      run_to_done(5);
    end
  endtask

  initial begin : receiver
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result(out_word);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_request && !hold_taken) begin
        hold_left = 200;
        hold_taken = 1'b1;
      end
      out_stall <= (hold_left > 0) || (stall_on && $urandom_range(0, 99) < 27);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    jmse_in_t w;
    @(posedge clk);
    while (rst) @(posedge clk);

    w = random_word(OP_TICK);
    w.tdo_pin = 1'b1;
    w.tdi_byte = 8'hFF;
    w.bit_count = 4'hF;
    w.pulse_count = 8'hFF;
    w.tms_level = 1'b1;
    w.tdi_level = 1'b1;
    send_word(w);
    w = random_word(OP_SET_PINS);
    w.tms_level = 1'b1;
    w.tdi_level = 1'b1;
    send_word(w);
    w.tms_level = 1'b0;
    w.tdi_level = 1'b0;
    send_word(w);
    w = random_word(OP_SHIFT);
    w.bit_count = 4'd0;
    send_word(w);

    w = random_word(OP_SHIFT);
    w.tdi_byte = 8'hA5;
    w.bit_count = 4'd8;
    send_word(w);
    send_word(random_word(OP_TICK));
    send_word(random_word(OP_STROBE));
    send_word(random_word(OP_SHIFT));
    send_word(random_word(OP_SET_PINS));
    run_to_done(0);

    w = random_word(OP_SHIFT);
    w.tdi_byte = 8'hFF;
    w.bit_count = 4'd15;
    send_word(w);
    run_to_done(0);
    w = random_word(OP_SHIFT);
    w.tdi_byte = 8'h00;
    w.bit_count = 4'd9;
    send_word(w);
    run_to_done(0);

    w = random_word(OP_STROBE);
    w.pulse_count = 8'd0;
    w.tdo_pin = 1'b1;
    send_word(w);
    w.tdo_pin = 1'b0;
    send_word(w);
    w = random_word(OP_STROBE);
    w.pulse_count = 8'd1;
    w.tms_level = 1'b1;
    w.tdi_level = 1'b0;
    send_word(w);
    run_to_done(0);
    w = random_word(OP_STROBE);
    w.pulse_count = 8'd3;
    w.tms_level = 1'b0;
    w.tdi_level = 1'b1;
    send_word(w);
    run_to_done(0);

    // A zero half-period runs like one tick per half-period.
    settle();
    write_half_period(16'd0);
    w = random_word(OP_STROBE);
    w.pulse_count = 8'd255;
    send_word(w);
    run_to_done(0);
    w = random_word(OP_SHIFT);
    w.bit_count = 4'd1;
    send_word(w);
    run_to_done(0);

    // A long half-period, for a single bit only.
    settle();
    write_half_period(16'd40);
    w = random_word(OP_SHIFT);
    w.tdi_byte = 8'h80;
    w.bit_count = 4'd1;
    send_word(w);
    run_to_done(0);

    settle();
    write_half_period(16'd1);
    hold_request = 1'b1;
    random_phase(RANDOM_WORDS);

    settle();
    write_half_period(16'd3);
    idle_on = 1'b0;
    stall_on = 1'b0;
    random_phase(RANDOM_WORDS);
    idle_on = 1'b1;
    stall_on = 1'b1;

    settle();
    write_half_period(16'd0);
    random_phase(RANDOM_WORDS);

    settle();
    write_half_period(16'd2);
    random_phase(RANDOM_WORDS);

    settle();
    write_half_period(16'($urandom_range(1, 5)));
    random_phase(RANDOM_WORDS);

    settle();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
